/* src/vtcm_pkg.sv */
`default_nettype none

package vtcm_pkg;

  // position arithmetic
  localparam int POS_W         = 32;
  localparam int PROD_W        = 2 * POS_W;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fff_ffff;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

  // colour arithmetic: channel = (byte * tint + 127) / 255
  localparam int BYTE_W      = 8;
  localparam int CH_W        = 16;
  localparam int CPROD_W     = BYTE_W + CH_W;
  localparam int RECIP_W     = 25;
  localparam int CMUL_W      = CPROD_W + RECIP_W;
  localparam int RECIP_SHIFT = 32;
  // ceil(2^32 / 255); exact floor division for every numerator below 2^24
  localparam logic [RECIP_W-1:0] RECIP_255  = 25'd16843010;
  localparam logic [CPROD_W-1:0] ROUND_HALF = 24'd127;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;

  typedef enum logic [2:0] {
    REG_ROW0     = 3'd0,
    REG_ROW1     = 3'd1,
    REG_ROW2     = 3'd2,
    REG_XLATE_XY = 3'd3,
    REG_XLATE_Z  = 3'd4,
    REG_TINT     = 3'd5
  } reg_idx_t;

  localparam logic [CFG_DATA_W-1:0] ROW0_RST = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] ROW1_RST = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] TINT_RST = 64'h8000_8000_8000_8000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] tex_u;
    logic        [31:0] tex_v;
    logic        [31:0] packed_color;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic        [31:0] out_u;
    logic        [31:0] out_v;
    logic        [15:0] red;
    logic        [15:0] green;
    logic        [15:0] blue;
    logic        [15:0] alpha;
  } out_t;

endpackage

`default_nettype wire

/* src/vertex_transform_color_modulate_core.sv */
`default_nettype none

// vertex transform and colour modulate core
//
// input channel (in_valid / in_stall / in_data): one vertex per request, a
// Q16.16 position, two raw texture coordinates and a packed ARGB colour.
// result channel (out_valid / out_stall / out_data): one result per vertex,
// the world x, y, z (saturated Q16.16), the copied texture coordinates and
// four Q1.15 colour channels, in request order.
// config port (cfg_*): APB-style, 64-bit registers at byte address 8*index;
// write only while the pipe is empty.
// path: a request passes the stage 1, stage 2 and stage 3 registers before
// out_valid rises; the result is taken at an edge where out_stall is low.
// throughput: one request per clock when not stalled; three register stages
// (32x32 multiplies, wide add, floor shift plus translate and saturate).
// stall: each stage holds while the stage after it is full and held, so a
// held result still lets requests fill the empty stages behind it.
// reset: rst_n synchronous active low clears all stage valids and loads the
// identity matrix, zero translation and unity tint.

module vertex_transform_color_modulate_core
  import vtcm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // input channel
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire in_t               in_data,
  // result channel
  output logic                   out_valid,
  input  wire                    out_stall,
  output out_t                   out_data,
  // config port
  input  wire                    cfg_psel,
  input  wire                    cfg_penable,
  input  wire                    cfg_pwrite,
  input  wire [CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire [CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  // width of the floored sum and of the sum plus translation
  localparam int SHW = PROD_W + 1 - FRAC_BITS;
  localparam int RW  = SHW + 1;
  localparam logic signed [RW-1:0] SAT_MAX = RW'(POS_MAX);
  localparam logic signed [RW-1:0] SAT_MIN = RW'(POS_MIN);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] row0_r, row1_r, row2_r, xlate_xy_r, tint_r;
  logic [POS_W-1:0]      xlate_z_r;
  reg_idx_t              cfg_idx;
  logic                  cfg_wr;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r     <= ROW0_RST;
      row1_r     <= ROW1_RST;
      row2_r     <= '0;
      xlate_xy_r <= '0;
      xlate_z_r  <= '0;
      tint_r     <= TINT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROW0:     row0_r     <= cfg_pwdata;
        REG_ROW1:     row1_r     <= cfg_pwdata;
        REG_ROW2:     row2_r     <= cfg_pwdata;
        REG_XLATE_XY: xlate_xy_r <= cfg_pwdata;
        REG_XLATE_Z:  xlate_z_r  <= cfg_pwdata[POS_W-1:0];
        REG_TINT:     tint_r     <= cfg_pwdata;
        default: ;  // unused indexes ignore writes
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROW0:     cfg_prdata = row0_r;
      REG_ROW1:     cfg_prdata = row1_r;
      REG_ROW2:     cfg_prdata = row2_r;
      REG_XLATE_XY: cfg_prdata = xlate_xy_r;
      REG_XLATE_Z:  cfg_prdata = CFG_DATA_W'(xlate_z_r);
      REG_TINT:     cfg_prdata = tint_r;
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // stage advance: a stage loads when empty or when its content moves on
  // ---------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r;
  logic ce1, ce2, ce3;

  assign ce3      = !s3_valid_r || !out_stall;
  assign ce2      = !s2_valid_r || ce3;
  assign ce1      = !s1_valid_r || ce2;
  assign in_stall = !ce1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (ce1) s1_valid_r <= in_valid;
      if (ce2) s2_valid_r <= s1_valid_r;
      if (ce3) s3_valid_r <= s2_valid_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: matrix products and colour byte times tint
  // ---------------------------------------------------------------------
  logic signed [POS_W-1:0]  coef [3][2];
  logic signed [POS_W-1:0]  pos  [2];
  logic [BYTE_W-1:0]        cbyte [4];  // red, green, blue, alpha
  logic signed [PROD_W-1:0] s1_prod_nxt [3][2];
  logic [CPROD_W-1:0]       s1_cprod_nxt [4];

  logic signed [PROD_W-1:0] s1_prod_r  [3][2];
  logic [CPROD_W-1:0]       s1_cprod_r [4];
  logic [31:0]              s1_u_r, s1_v_r;

  assign coef[0][0] = $signed(row0_r[31:0]);
  assign coef[0][1] = $signed(row0_r[63:32]);
  assign coef[1][0] = $signed(row1_r[31:0]);
  assign coef[1][1] = $signed(row1_r[63:32]);
  assign coef[2][0] = $signed(row2_r[31:0]);
  assign coef[2][1] = $signed(row2_r[63:32]);
  assign pos[0]     = in_data.pos_x;
  assign pos[1]     = in_data.pos_y;

  // argb byte order in the packed word
  assign cbyte[0] = in_data.packed_color[23:16];
  assign cbyte[1] = in_data.packed_color[15:8];
  assign cbyte[2] = in_data.packed_color[7:0];
  assign cbyte[3] = in_data.packed_color[31:24];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 2; c++) begin
        s1_prod_nxt[r][c] = PROD_W'(coef[r][c]) * PROD_W'(pos[c]);
      end
    end
    for (int k = 0; k < 4; k++) begin
      s1_cprod_nxt[k] = CPROD_W'(cbyte[k]) * CPROD_W'(tint_r[CH_W*k +: CH_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce1) begin
      s1_prod_r  <= s1_prod_nxt;
      s1_cprod_r <= s1_cprod_nxt;
      s1_u_r     <= in_data.tex_u;
      s1_v_r     <= in_data.tex_v;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: exact sum of the two products; colour reciprocal multiply
  // ---------------------------------------------------------------------
  logic signed [PROD_W:0] s2_sum_nxt [3];
  logic [CMUL_W-1:0]      s2_cmul_nxt [4];

  logic signed [PROD_W:0] s2_sum_r  [3];
  logic [CMUL_W-1:0]      s2_cmul_r [4];
  logic [31:0]            s2_u_r, s2_v_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s2_sum_nxt[r] = (PROD_W+1)'(s1_prod_r[r][0]) + (PROD_W+1)'(s1_prod_r[r][1]);
    end
    // round to nearest, then divide by 255 through the reciprocal
    for (int k = 0; k < 4; k++) begin
      s2_cmul_nxt[k] = CMUL_W'(s1_cprod_r[k] + ROUND_HALF) * CMUL_W'(RECIP_255);
    end
  end

  always_ff @(posedge clk) begin
    if (ce2) begin
      s2_sum_r  <= s2_sum_nxt;
      s2_cmul_r <= s2_cmul_nxt;
      s2_u_r    <= s1_u_r;
      s2_v_r    <= s1_v_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: floor shift, translate, saturate; colour quotient
  // ---------------------------------------------------------------------
  logic signed [POS_W-1:0] xl     [3];
  logic signed [SHW-1:0]   s3_flr [3];
  logic signed [RW-1:0]    s3_res [3];
  logic signed [POS_W-1:0] s3_sat [3];
  logic [CH_W-1:0]         s3_ch  [4];
  out_t                    out_nxt;
  out_t                    out_r;

  assign xl[0] = $signed(xlate_xy_r[31:0]);
  assign xl[1] = $signed(xlate_xy_r[63:32]);
  assign xl[2] = $signed(xlate_z_r);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      // dropping the low fraction bits of a two's complement value is a floor
      s3_flr[r] = s2_sum_r[r][PROD_W:FRAC_BITS];
      s3_res[r] = RW'(s3_flr[r]) + RW'(xl[r]);
      if (s3_res[r] > SAT_MAX) begin
        s3_sat[r] = POS_MAX;
      end else if (s3_res[r] < SAT_MIN) begin
        s3_sat[r] = POS_MIN;
      end else begin
        s3_sat[r] = s3_res[r][POS_W-1:0];
      end
    end
    for (int k = 0; k < 4; k++) begin
      s3_ch[k] = s2_cmul_r[k][RECIP_SHIFT +: CH_W];
    end
    out_nxt.out_x = s3_sat[0];
    out_nxt.out_y = s3_sat[1];
    out_nxt.out_z = s3_sat[2];
    out_nxt.out_u = s2_u_r;
    out_nxt.out_v = s2_v_r;
    out_nxt.red   = s3_ch[0];
    out_nxt.green = s3_ch[1];
    out_nxt.blue  = s3_ch[2];
    out_nxt.alpha = s3_ch[3];
  end

  always_ff @(posedge clk) begin
    if (ce3) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* src/vtcm_checker.sv */
`default_nettype none

module vtcm_checker
  import vtcm_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire out_t out_data
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an unstalled result side never back-pressures the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while result side is free");

  // a held result keeps its request
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // a result leaves only when taken
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result withdrawn without being taken");

endmodule

bind vertex_transform_color_modulate_core vtcm_checker u_vtcm_checker (.*);

`default_nettype wire

/* tb/tb_vertex_transform_color_modulate_core.sv */
module tb_vertex_transform_color_modulate_core
  import vtcm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400_000;
  // indexes past the last register, writes there must be dropped
  localparam logic [2:0] UNMAPPED_LO = 3'd6;
  localparam logic [2:0] UNMAPPED_HI = 3'd7;
  // coefficient styles for random phases
  localparam int STYLE_SMALL   = 0;
  localparam int STYLE_FULL    = 1;
  localparam int STYLE_EXTREME = 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // request channel
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;

  // result channel
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // register port
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  vertex_transform_color_modulate_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow copy of the register file, reset values
  logic [63:0] coef_row0 = ROW0_RST;
  logic [63:0] coef_row1 = ROW1_RST;
  logic [63:0] coef_row2 = '0;
  logic [63:0] offset_xy = '0;
  logic [63:0] offset_z  = '0;
  logic [63:0] tint_gain = TINT_RST;

  in_t  vertex_q[$];   // requests waiting to be driven
  out_t world_q[$];    // expected results, oldest first
  int   n_queued = 0;
  int   n_accepted = 0;
  int   mismatches = 0;
  int   cycle_count = 0;

  // one row of the affine transform: exact sum of both products, floor, translate, clamp
  function automatic logic [31:0] affine_lane(logic signed [31:0] a, logic signed [31:0] b,
                                              logic signed [31:0] x, logic signed [31:0] y,
                                              logic signed [31:0] t);
    logic signed [63:0] pa;
    logic signed [63:0] pb;
    logic signed [65:0] acc;
    pa = a * x;
    pb = b * y;
    acc = pa + pb;
    acc = (acc >>> FRAC_BITS_DEF) + t;
    if (acc > POS_MAX) return POS_MAX;
    if (acc < POS_MIN) return POS_MIN;
    return acc[31:0];
  endfunction

  // level/255 times gain, rounded to nearest
  function automatic logic [15:0] tinted(logic [7:0] level, logic [15:0] gain);
    logic [24:0] num;
    num = level * gain + 25'd127;
    return 16'(num / 25'd255);
  endfunction

  function automatic out_t transform_vertex(in_t v);
    out_t r;
    r.out_x = affine_lane(coef_row0[31:0], coef_row0[63:32], v.pos_x, v.pos_y, offset_xy[31:0]);
    r.out_y = affine_lane(coef_row1[31:0], coef_row1[63:32], v.pos_x, v.pos_y,
                          offset_xy[63:32]);
    r.out_z = affine_lane(coef_row2[31:0], coef_row2[63:32], v.pos_x, v.pos_y, offset_z[31:0]);
    r.out_u = v.tex_u;
    r.out_v = v.tex_v;
    r.red   = tinted(v.packed_color[23:16], tint_gain[15:0]);
    r.green = tinted(v.packed_color[15:8],  tint_gain[31:16]);
    r.blue  = tinted(v.packed_color[7:0],   tint_gain[47:32]);
    r.alpha = tinted(v.packed_color[31:24], tint_gain[63:48]);
    return r;
  endfunction

  // mostly short gaps, a few long ones, none at all while bursting
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(99);
    if (burst || r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [31:0] rand_coef(int style);
    case (style)
      STYLE_SMALL: return 32'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
      STYLE_FULL:  return $urandom();
      default: begin
        case ($urandom_range(4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0001_0000;
          3: return 32'hffff_0000;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] rand_gain(int style);
    case (style)
      STYLE_SMALL: return 16'($urandom_range(16'h8000));
      STYLE_FULL:  return 16'($urandom_range(16'hffff));
      default: begin
        case ($urandom_range(2))
          0: return 16'h0000;
          1: return 16'h8000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  // positions: mostly within +-8.0, some anywhere, some at the limits
  function automatic in_t rand_vertex();
    in_t v;
    int pick;
    pick = $urandom_range(9);
    v.pos_x = rand_coef(pick < 6 ? STYLE_SMALL : (pick < 9 ? STYLE_FULL : STYLE_EXTREME));
    pick = $urandom_range(9);
    v.pos_y = rand_coef(pick < 6 ? STYLE_SMALL : (pick < 9 ? STYLE_FULL : STYLE_EXTREME));
    v.tex_u = $urandom();
    v.tex_v = $urandom();
    v.packed_color = $urandom();
    return v;
  endfunction

  task automatic queue_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] u,
                              logic [31:0] v, logic [31:0] color);
    vertex_q.push_back('{x, y, u, v, color});
    n_queued++;
  endtask

  // setup cycle, then access cycle; shadow copy follows the write
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 3'b000});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_ROW0:     coef_row0 = value;
      REG_ROW1:     coef_row1 = value;
      REG_ROW2:     coef_row2 = value;
      REG_XLATE_XY: offset_xy = value;
      REG_XLATE_Z:  offset_z  = {32'd0, value[31:0]};
      REG_TINT:     tint_gain = value;
      default: ;
    endcase
  endtask

  task automatic load_random_config(int style);
    write_reg(REG_ROW0, {rand_coef(style), rand_coef(style)});
    write_reg(REG_ROW1, {rand_coef(style), rand_coef(style)});
    write_reg(REG_ROW2, {rand_coef(style), rand_coef(style)});
    write_reg(REG_XLATE_XY, {rand_coef(style), rand_coef(style)});
    // upper half is junk, only the low word counts
    write_reg(REG_XLATE_Z, {32'($urandom()), rand_coef(style)});
    write_reg(REG_TINT, {rand_gain(style), rand_gain(style), rand_gain(style),
                         rand_gain(style)});
  endtask

  // pipe empty: every request accepted and answered, then a further idle wait
  task automatic drain();
    while (n_accepted != n_queued || world_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // request driver: holds the payload while stalled, random gaps between requests
  int send_gap = 0;
  bit send_burst = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        world_q.push_back(transform_vertex(in_data));
        n_accepted++;
      end
      if ($urandom_range(199) == 0) send_burst = !send_burst;
      if (!in_valid || !in_stall) begin
        if (send_gap == 0 && vertex_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= vertex_q.pop_front();
          send_gap = pick_gap(send_burst);
        end else begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // result monitor: compares against the oldest expectation, stalls at random
  int stall_left = 0;
  bit recv_burst = 1'b0;
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (world_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = world_q.pop_front();
          check_field("out_x", want.out_x, out_data.out_x);
          check_field("out_y", want.out_y, out_data.out_y);
          check_field("out_z", want.out_z, out_data.out_z);
          check_field("out_u", want.out_u, out_data.out_u);
          check_field("out_v", want.out_v, out_data.out_v);
          check_field("red",   want.red,   out_data.red);
          check_field("green", want.green, out_data.green);
          check_field("blue",  want.blue,  out_data.blue);
          check_field("alpha", want.alpha, out_data.alpha);
        end
      end
      if ($urandom_range(199) == 0) recv_burst = !recv_burst;
      if (stall_left == 0) stall_left = pick_gap(recv_burst);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int styles[8];
    styles = '{STYLE_SMALL, STYLE_SMALL, STYLE_FULL, STYLE_EXTREME,
               STYLE_SMALL, STYLE_FULL, STYLE_SMALL, STYLE_EXTREME};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: identity matrix, unity tint
    queue_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_vertex(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_vertex(32'h8000_0000, 32'h7fff_ffff, 32'haaaa_aaaa, 32'h5555_5555, 32'hff00_ff00);
    queue_vertex(32'h0001_8000, 32'hfffe_8000, 32'h5555_5555, 32'haaaa_aaaa, 32'h00ff_00ff);
    queue_vertex(32'h0000_0001, 32'hffff_ffff, 32'h1234_5678, 32'h9abc_def0, 32'h8080_8080);
    // rounding right around half a step
    queue_vertex(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0101_7f7f);
    drain();

    // largest coefficients and offsets: positive and negative saturation, gains near two
    write_reg(REG_ROW0, 64'h7fff_ffff_7fff_ffff);
    write_reg(REG_ROW1, 64'h8000_0000_8000_0000);
    write_reg(REG_ROW2, 64'h8000_0000_7fff_ffff);
    write_reg(REG_XLATE_XY, 64'h8000_0000_7fff_ffff);
    write_reg(REG_XLATE_Z, 64'hdead_beef_7fff_ffff);
    write_reg(REG_TINT, 64'hffff_ffff_ffff_ffff);
    // writes past the register file are dropped
    write_reg(UNMAPPED_LO, 64'h0123_4567_89ab_cdef);
    write_reg(UNMAPPED_HI, 64'hfedc_ba98_7654_3210);
    queue_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
    queue_vertex(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff);
    queue_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001, 32'h7fff_fffe, 32'h8040_20c0);
    queue_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0102_0304);
    queue_vertex(32'h0000_0001, 32'hffff_ffff, 32'hffff_fffe, 32'h0000_0002, 32'hfefd_fcfb);
    drain();

    // everything zero
    write_reg(REG_ROW0, '0);
    write_reg(REG_ROW1, '0);
    write_reg(REG_ROW2, '0);
    write_reg(REG_XLATE_XY, '0);
    write_reg(REG_XLATE_Z, '0);
    write_reg(REG_TINT, '0);
    queue_vertex(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_vertex(32'h1234_5678, 32'h8765_4321, 32'h0000_0000, 32'h0000_0000, 32'h7f7f_7f7f);
    drain();

    // half-step coefficients to probe the floor, tints near zero, one and two
    write_reg(REG_ROW0, 64'hffff_8000_0000_8000);
    write_reg(REG_ROW1, 64'h0000_8000_0000_8000);
    write_reg(REG_ROW2, 64'hffff_8000_ffff_8000);
    write_reg(REG_XLATE_XY, 64'hffff_ffff_0000_0001);
    write_reg(REG_XLATE_Z, 64'h0000_0000_8000_0000);
    write_reg(REG_TINT, 64'hfffe_8001_7fff_0001);
    queue_vertex(32'h0000_0001, 32'h0000_0001, 32'hc3c3_c3c3, 32'h3c3c_3c3c, 32'hffff_ffff);
    queue_vertex(32'hffff_ffff, 32'hffff_ffff, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0101_0101);
    queue_vertex(32'h0000_0003, 32'hffff_fffd, 32'h0000_ffff, 32'hffff_0000, 32'h80ff_7f01);
    drain();

    // random phases, each under a fresh register setting
    foreach (styles[p]) begin
      load_random_config(styles[p]);
      repeat (63) begin
        vertex_q.push_back(rand_vertex());
        n_queued++;
      end
      drain();
    end

    if (mismatches == 0 && world_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
src/vtcm_pkg.sv
src/vertex_transform_color_modulate_core.sv
src/vtcm_checker.sv
tb/tb_vertex_transform_color_modulate_core.sv
